### rtl/core/nus_pkg.sv
// Package for the NAL unit splitter: queue sizing, command codes, start code and unit type constants.
// No dependencies.
package nus_pkg;

  localparam int QUEUE_DEPTH = 4096;
  localparam int AW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = AW + 1;
  localparam int CODE_LEN    = 4;
  localparam int NUM_BANKS   = CODE_LEN;
  localparam int BANK_W      = $clog2(NUM_BANKS);
  localparam int ROW_W       = AW - BANK_W;
  localparam int BANK_DEPTH  = QUEUE_DEPTH / NUM_BANKS;
  localparam int STAGE_MAX   = QUEUE_DEPTH + CODE_LEN;
  localparam int TYPE_W      = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [CW:0]       DEPTH_X    = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0]     STAGE_MAX_C = CW'(STAGE_MAX);
  localparam logic [CW-1:0]     CODE_LEN_C = CW'(CODE_LEN);
  localparam logic [TYPE_W-1:0] IDR_TYPE   = TYPE_W'(5);

  localparam logic [7:0] START_CODE [CODE_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

endpackage

### rtl/core/nus_if.sv
// Valid/ready channels of the NAL unit splitter: stream/pop items in, result items out.
// Depends on nus_pkg.
interface nus_in_if import nus_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface nus_out_if import nus_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic              out_valid;
  logic              unit_committed;
  logic              unit_dropped;
  logic              resync_waiting;
  logic [TYPE_W-1:0] unit_type;
  logic [CW-1:0]     queue_level;

  modport source (output valid, out_byte, out_valid, unit_committed, unit_dropped,
                  resync_waiting, unit_type, queue_level, input ready);
  modport sink   (input valid, out_byte, out_valid, unit_committed, unit_dropped,
                  resync_waiting, unit_type, queue_level, output ready);
endinterface

### rtl/core/nal_unit_splitter_with_fifo.sv
// NAL unit splitter in front of a byte queue held in four interleaved RAM banks.
// Input register, then result register; one item per cycle unless the output stalls.
// A start code writes its four bytes at once, one per bank.
// Reset (async, active low) clears pointers, counts, matcher and flags; RAM is not cleared.
// Depends on nus_pkg, nus_if (nus_in_if, nus_out_if) and nus_ram.
module nal_unit_splitter_with_fifo import nus_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nus_in_if.sink      in_i,
  nus_out_if.source   out_o
);

  // input register
  logic       in_vq;
  logic       cmd_q;
  logic [7:0] byte_q;

  // splitter state
  logic [AW-1:0]     read_pos_q, read_pos_d;
  logic [AW-1:0]     commit_pos_q, commit_pos_d;
  logic [CW-1:0]     committed_q, committed_d;
  logic [CW-1:0]     staged_q, staged_d;
  logic [CW-1:0]     lost_at_q, lost_at_d;
  logic [1:0]        match_q, match_d;
  logic              start_seen_q, start_seen_d;
  logic              resync_q, resync_d;
  logic [TYPE_W-1:0] stype_q, stype_d;

  // result register
  logic              res_vq;
  logic              ovalid_q, ovalid_d;
  logic              ocommit_q, ocommit_d;
  logic              odrop_q, odrop_d;
  logic [TYPE_W-1:0] otype_q, otype_d;
  logic [BANK_W-1:0] rbank_q;

  logic adv, proc;

  logic              bank_we    [NUM_BANKS];
  logic [ROW_W-1:0]  bank_waddr [NUM_BANKS];
  logic [7:0]        bank_wdata [NUM_BANKS];
  logic [7:0]        bank_rdata [NUM_BANKS];
  logic              rd_en;

  assign adv        = !res_vq || out_o.ready;
  assign proc       = in_vq && adv;
  assign in_i.ready = !in_vq || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vq <= 1'b1;
    end else if (proc) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.cmd;
      byte_q <= in_i.data_byte;
    end
  end

  always_comb begin
    logic [CW:0]       sum_idx;
    logic [CW:0]       sum_len;
    logic [CW:0]       sum_k;
    logic [CW-1:0]     len;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     addr_k;
    logic [BANK_W-1:0] bk;
    logic              found;
    logic              keep;

    read_pos_d   = read_pos_q;
    commit_pos_d = commit_pos_q;
    committed_d  = committed_q;
    staged_d     = staged_q;
    lost_at_d    = lost_at_q;
    match_d      = match_q;
    start_seen_d = start_seen_q;
    resync_d     = resync_q;
    stype_d      = stype_q;
    ovalid_d     = 1'b0;
    ocommit_d    = 1'b0;
    odrop_d      = 1'b0;
    otype_d      = '0;
    rd_en        = 1'b0;
    found        = 1'b0;
    len          = '0;
    sum_len      = '0;
    sum_k        = '0;
    keep         = 1'b0;
    addr_k       = '0;
    bk           = '0;
    for (int j = 0; j < NUM_BANKS; j++) begin
      bank_we[j]    = 1'b0;
      bank_waddr[j] = '0;
      bank_wdata[j] = '0;
    end

    sum_idx = {1'b0, committed_q} + {1'b0, staged_q};
    waddr   = commit_pos_q + staged_q[AW-1:0];

    if (proc) begin
      if (cmd_q == CMD_POP) begin
        if (committed_q != '0) begin
          rd_en       = 1'b1;
          ovalid_d    = 1'b1;
          read_pos_d  = read_pos_q + AW'(1);
          committed_d = committed_q - CW'(1);
        end
      end else begin
        if (byte_q == START_CODE[0]) begin
          if (match_q != 2'd3) begin
            match_d = match_q + 2'd1;
          end
        end else begin
          found   = (byte_q == START_CODE[CODE_LEN-1]) && (match_q == 2'd3);
          match_d = '0;
        end

        if (start_seen_q) begin
          if (staged_q == CODE_LEN_C) begin
            stype_d = byte_q[TYPE_W-1:0];
          end
          if (sum_idx < DEPTH_X) begin
            if (!found) begin
              bank_we[waddr[BANK_W-1:0]]    = 1'b1;
              bank_waddr[waddr[BANK_W-1:0]] = waddr[AW-1:BANK_W];
              bank_wdata[waddr[BANK_W-1:0]] = byte_q;
            end
          end else if (lost_at_q > staged_q) begin
            lost_at_d = staged_q;
          end
          if (staged_q < STAGE_MAX_C) begin
            staged_d = staged_q + CW'(1);
          end
        end

        if (found) begin
          if (start_seen_q) begin
            len     = staged_d - CODE_LEN_C;
            sum_len = {1'b0, committed_q} + {1'b0, len};
            otype_d = stype_d;
            if (lost_at_d >= len && sum_len < DEPTH_X) begin
              if (!resync_q || stype_d == IDR_TYPE) begin
                commit_pos_d = commit_pos_q + len[AW-1:0];
                committed_d  = sum_len[CW-1:0];
                resync_d     = 1'b0;
                ocommit_d    = 1'b1;
              end else begin
                odrop_d = 1'b1;
              end
            end else begin
              odrop_d  = 1'b1;
              resync_d = 1'b1;
            end
          end
          // open the next unit: its start code lands one byte per bank
          lost_at_d = STAGE_MAX_C;
          for (int k = CODE_LEN - 1; k >= 0; k--) begin
            sum_k  = {1'b0, committed_d} + (CW + 1)'(k);
            keep   = sum_k < DEPTH_X;
            addr_k = commit_pos_d + AW'(k);
            bk     = addr_k[BANK_W-1:0];
            bank_we[bk]    = keep;
            bank_waddr[bk] = addr_k[AW-1:BANK_W];
            bank_wdata[bk] = START_CODE[k];
            if (!keep) begin
              lost_at_d = CW'(k);
            end
          end
          stype_d      = '0;
          staged_d     = CODE_LEN_C;
          start_seen_d = 1'b1;
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    nus_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (bank_waddr[g]),
      .wdata_i (bank_wdata[g]),
      .re_i    (rd_en && (read_pos_q[BANK_W-1:0] == BANK_W'(g))),
      .raddr_i (read_pos_q[AW-1:BANK_W]),
      .rdata_o (bank_rdata[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos_q   <= '0;
      commit_pos_q <= '0;
      committed_q  <= '0;
      staged_q     <= '0;
      lost_at_q    <= STAGE_MAX_C;
      match_q      <= '0;
      start_seen_q <= 1'b0;
      resync_q     <= 1'b0;
      stype_q      <= '0;
      res_vq       <= 1'b0;
    end else begin
      read_pos_q   <= read_pos_d;
      commit_pos_q <= commit_pos_d;
      committed_q  <= committed_d;
      staged_q     <= staged_d;
      lost_at_q    <= lost_at_d;
      match_q      <= match_d;
      start_seen_q <= start_seen_d;
      resync_q     <= resync_d;
      stype_q      <= stype_d;
      if (proc) begin
        res_vq <= 1'b1;
      end else if (out_o.ready) begin
        res_vq <= 1'b0;
      end
    end
  end

  logic              oresync_q;
  logic [CW-1:0]     olevel_q;

  always_ff @(posedge clk_i) begin
    if (proc) begin
      ovalid_q  <= ovalid_d;
      ocommit_q <= ocommit_d;
      odrop_q   <= odrop_d;
      otype_q   <= otype_d;
      oresync_q <= resync_d;
      olevel_q  <= committed_d;
      rbank_q   <= read_pos_q[BANK_W-1:0];
    end
  end

  assign out_o.valid          = res_vq;
  assign out_o.out_byte       = ovalid_q ? bank_rdata[rbank_q] : 8'h00;
  assign out_o.out_valid      = ovalid_q;
  assign out_o.unit_committed = ocommit_q;
  assign out_o.unit_dropped   = odrop_q;
  assign out_o.resync_waiting = oresync_q;
  assign out_o.unit_type      = otype_q;
  assign out_o.queue_level    = olevel_q;

endmodule

### rtl/core/nus_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module nus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/nus_checker.sv
// Scoreboard for the NAL unit splitter: watches both channels, predicts each result item.
// Holds its own copy of the staging ring and queue pointers. Depends on nus_pkg and nus_if.
module nus_checker import nus_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  nus_in_if    in_i,
  nus_out_if   res_i,
  output int   err_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              out_valid;
    logic              committed;
    logic              dropped;
    logic              resync;
    logic [TYPE_W-1:0] unit_type;
    logic [CW-1:0]     level;
  } split_result_t;

  logic [7:0]        ring_bytes [QUEUE_DEPTH];
  int unsigned       rd_ptr;
  int unsigned       tail_ptr;
  int unsigned       held_cnt;
  int unsigned       staged_len;
  int unsigned       lost_idx;
  int unsigned       zero_run;
  bit                have_start;
  bit                resync_on;
  logic [TYPE_W-1:0] cur_type;

  split_result_t expected_results [$];
  split_result_t exp_r;

  function automatic void stage_into_ring(int unsigned idx, logic [7:0] b);
    if (held_cnt + idx < QUEUE_DEPTH) begin
      ring_bytes[(tail_ptr + idx) % QUEUE_DEPTH] = b;
    end else if (lost_idx > idx) begin
      lost_idx = idx;
    end
  endfunction

  function automatic split_result_t split_step(logic c, logic [7:0] b);
    split_result_t r;
    bit            hit;
    int unsigned   ulen;
    int unsigned   room;
    r   = '0;
    hit = 1'b0;
    if (c == CMD_POP) begin
      if (held_cnt > 0) begin
        r.out_byte  = ring_bytes[rd_ptr];
        r.out_valid = 1'b1;
        rd_ptr      = (rd_ptr + 1) % QUEUE_DEPTH;
        held_cnt--;
      end
    end else begin
      if (have_start) begin
        if (staged_len == CODE_LEN) cur_type = b[TYPE_W-1:0];
        stage_into_ring(staged_len, b);
        if (staged_len < STAGE_MAX) staged_len++;
      end
      if (b == 8'h00) begin
        if (zero_run < 3) zero_run++;
      end else if (b == 8'h01 && zero_run == 3) begin
        hit      = 1'b1;
        zero_run = 0;
      end else begin
        zero_run = 0;
      end
      if (hit) begin
        if (have_start) begin
          ulen        = (staged_len >= CODE_LEN) ? staged_len - CODE_LEN : 0;
          room        = QUEUE_DEPTH - held_cnt;
          r.unit_type = cur_type;
          if (lost_idx >= ulen && room > ulen) begin
            if (!resync_on || cur_type == IDR_TYPE) begin
              tail_ptr    = (tail_ptr + ulen) % QUEUE_DEPTH;
              held_cnt    = held_cnt + ulen;
              resync_on   = 1'b0;
              r.committed = 1'b1;
            end else begin
              r.dropped = 1'b1;
            end
          end else begin
            r.dropped = 1'b1;
            resync_on = 1'b1;
          end
        end
        lost_idx = STAGE_MAX;
        cur_type = '0;
        for (int k = 0; k < CODE_LEN; k++) stage_into_ring(k, START_CODE[k]);
        staged_len = CODE_LEN;
        have_start = 1'b1;
      end
    end
    r.resync = resync_on;
    r.level  = held_cnt[CW-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr      = 0;
      tail_ptr    = 0;
      held_cnt    = 0;
      staged_len  = 0;
      lost_idx    = STAGE_MAX;
      zero_run    = 0;
      have_start  = 1'b0;
      resync_on   = 1'b0;
      cur_type    = '0;
      err_count_o = 0;
      pending_o   <= 0;
      expected_results.delete();
    end else begin
      if (in_i.valid && in_i.ready) begin
        expected_results.push_back(split_step(in_i.cmd, in_i.data_byte));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expected item waiting");
          err_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("out_byte", 16'(exp_r.out_byte), 16'(res_i.out_byte));
          check_field("out_valid", 16'(exp_r.out_valid), 16'(res_i.out_valid));
          check_field("unit_committed", 16'(exp_r.committed), 16'(res_i.unit_committed));
          check_field("unit_dropped", 16'(exp_r.dropped), 16'(res_i.unit_dropped));
          check_field("resync_waiting", 16'(exp_r.resync), 16'(res_i.resync_waiting));
          check_field("unit_type", 16'(exp_r.unit_type), 16'(res_i.unit_type));
          check_field("queue_level", 16'(exp_r.level), 16'(res_i.queue_level));
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the NAL unit splitter testbench: clock, reset, stream and pop stimulus, verdict.
// Depends on nus_pkg, nus_if, nus_checker and the nal_unit_splitter_with_fifo RTL.
module testbench import nus_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   err_count;
  int   pending;
  int   sent_items;
  int   ready_hold = 0;
  bit   in_idle;
  bit   out_idle;

  nus_in_if  in_if ();
  nus_out_if out_if ();

  nal_unit_splitter_with_fifo i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  nus_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .res_i       (out_if),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      out_if.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (out_idle && $urandom_range(0, 99) < 20) ready_hold <= gap_len();
    end
  end

  task automatic send_item(logic c, logic [7:0] d);
    int gap;
    gap = 0;
    if (in_idle && $urandom_range(0, 99) < 30) gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= c;
    in_if.data_byte <= d;
    do @(posedge clk_i); while (!in_if.ready);
    sent_items++;
  endtask

  task automatic push_byte(logic [7:0] d);
    send_item(CMD_PUSH, d);
  endtask

  task automatic pop_bytes(int n);
    repeat (n) send_item(CMD_POP, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] body_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'h00;
    if (r < 17) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [TYPE_W-1:0] pick_type();
    if ($urandom_range(0, 3) == 0) return IDR_TYPE;
    return TYPE_W'($urandom_range(0, 31));
  endfunction

  // start code, then, when len > 0, a header byte carrying the type and len-1 body bytes
  task automatic emit_unit(logic [TYPE_W-1:0] ty, int len);
    logic [2:0] hi;
    hi = 3'($urandom_range(0, 7));
    for (int k = 0; k < CODE_LEN; k++) push_byte(START_CODE[k]);
    if (len > 0) push_byte({hi, ty});
    for (int k = 1; k < len; k++) push_byte(body_byte());
  endtask

  initial begin
    #50_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.cmd       = CMD_PUSH;
    in_if.data_byte = 8'h00;
    sent_items      = 0;
    in_idle         = 1'b1;
    out_idle        = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // leading garbage, long zero run before the first start code, IDR unit
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h01);
    repeat (5) push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'h65);
    push_byte(8'hFF);
    push_byte(8'h00);
    repeat (3) push_byte(8'h00);
    push_byte(8'h01);
    send_item(CMD_POP, 8'hFF);
    pop_bytes(3);
    // empty unit, then a header of type 31
    for (int k = 0; k < CODE_LEN; k++) push_byte(START_CODE[k]);
    push_byte(8'hFF);

    while (sent_items < 900) begin
      if (sent_items % 120 < 2) begin
        in_idle  = ($urandom_range(0, 3) != 0);
        out_idle = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 9)) inside
        [0:5]:   emit_unit(pick_type(), $urandom_range(0, 24));
        [6:8]:   pop_bytes($urandom_range(1, 8));
        default: repeat ($urandom_range(1, 6)) push_byte(body_byte());
      endcase
    end
    emit_unit(pick_type(), 3);
    pop_bytes(40);

    in_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
